### rtl/rbb_pkg.sv
// Package for the RGB 5x5 box blur: widths, codes, the job record shared by the
// front end, the queue and the back end, and the geometry record shared by the
// front and back ends. No dependencies.
package rbb_pkg;

	localparam int COL_W = 12;
	localparam int ROW_W = 13;
	localparam int FW_W = 11;
	localparam int FH_W = 13;
	localparam int SLOT_W = 3;
	localparam int CH_W = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int CNT_W = 6;
	localparam int SUM_W = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_RADIUS = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
	localparam logic [FH_W-1:0] FH_RESET = 13'd1024;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic [COL_W:0] w;
		logic [ROW_W-1:0] h;
	} geom_t;

	typedef struct packed {
		logic wr;
		logic [SLOT_W-1:0] wr_slot;
		logic [COL_W-1:0] wr_col;
		logic [PIX_W-1:0] pix;
		logic emit;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic [SLOT_W-1:0] out_slot;
		logic last;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage

### rtl/rbb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rbb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 6144
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/rbb_fifo.sv
// Short job queue between the front end and the back end.
// Depends on rbb_pkg for the job record.
module rbb_fifo #(
	parameter int DEPTH = rbb_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rbb_pkg::job_t wdata,
	output logic full,
	input  logic pop,
	output rbb_pkg::job_t rdata,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rbb_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0] count_q;

	assign full = (count_q == (PTR_W+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("job queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(DEPTH))
		else $error("job queue count out of range");

endmodule

### rtl/rbb_front.sv
// Front end of the box blur: configuration registers, input and output position
// tracking, and classification of each item into a job. Depends on rbb_pkg.
module rbb_front #(
	parameter int MAX_WIDTH = rbb_pkg::DEF_MAX_WIDTH,
	parameter int RADIUS = rbb_pkg::DEF_RADIUS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic op,
	input  logic [rbb_pkg::CH_W-1:0] red,
	input  logic [rbb_pkg::CH_W-1:0] green,
	input  logic [rbb_pkg::CH_W-1:0] blue,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rbb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic push,
	output rbb_pkg::job_t job,
	input  logic full,
	output rbb_pkg::geom_t geom
);

	localparam int RING = 2 * RADIUS + 2;
	localparam int N_W = rbb_pkg::ROW_W + rbb_pkg::COL_W + 1;

	logic [rbb_pkg::FW_W-1:0] fw_q;
	logic [rbb_pkg::FH_W-1:0] fh_q;
	logic [rbb_pkg::ROW_W-1:0] in_row_q, out_row_q;
	logic [rbb_pkg::COL_W-1:0] in_col_q, out_col_q;
	logic [rbb_pkg::SLOT_W-1:0] in_slot_q, out_slot_q;
	logic [N_W-1:0] n_q;

	logic [rbb_pkg::COL_W:0] w;
	logic [rbb_pkg::ROW_W-1:0] h;
	logic [N_W-1:0] lag;
	logic accept, restart, is_pixel, emit;
	logic [rbb_pkg::ROW_W-1:0] cur_row, cur_orow, o_row;
	logic [rbb_pkg::COL_W-1:0] cur_col, cur_ocol, o_col;
	logic [rbb_pkg::SLOT_W-1:0] cur_slot, cur_oslot, o_slot;
	logic [N_W-1:0] cur_n;
	logic in_wrap, out_wrap;

	always_comb begin
		if (fw_q == '0) begin
			w = (rbb_pkg::COL_W+1)'(1);
		end else if (int'(fw_q) > MAX_WIDTH) begin
			w = (rbb_pkg::COL_W+1)'(MAX_WIDTH);
		end else begin
			w = (rbb_pkg::COL_W+1)'(fw_q);
		end
		h = (fh_q == '0) ? rbb_pkg::ROW_W'(1) : fh_q;
		lag = N_W'(RADIUS) * N_W'(w)
			+ ((N_W'(RADIUS) < N_W'(w) - 1'b1) ? N_W'(RADIUS) : N_W'(w) - 1'b1);
	end

	assign geom = '{w: w, h: h};
	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign accept = in_valid && !in_stall;
	assign is_pixel = (op == rbb_pkg::OP_PIXEL);
	assign restart = (in_row_q >= h);

	always_comb begin
		cur_row = restart ? '0 : in_row_q;
		cur_col = restart ? '0 : in_col_q;
		cur_slot = restart ? '0 : in_slot_q;
		cur_n = restart ? '0 : n_q;
		cur_orow = restart ? '0 : out_row_q;
		cur_ocol = restart ? '0 : out_col_q;
		cur_oslot = restart ? '0 : out_slot_q;
		if (is_pixel) begin
			emit = (cur_n >= lag) && (cur_orow < h);
			o_row = cur_orow;
			o_col = cur_ocol;
			o_slot = cur_oslot;
		end else begin
			emit = restart && (out_row_q < h);
			o_row = out_row_q;
			o_col = out_col_q;
			o_slot = out_slot_q;
		end
		in_wrap = ((rbb_pkg::COL_W+1)'(cur_col) + 1'b1 == w);
		out_wrap = ((rbb_pkg::COL_W+1)'(o_col) + 1'b1 == w);
	end

	assign push = accept && (is_pixel || emit);

	always_comb begin
		job.wr = is_pixel;
		job.wr_slot = cur_slot;
		job.wr_col = cur_col;
		job.pix = {blue, green, red};
		job.emit = emit;
		job.out_row = o_row;
		job.out_col = o_col;
		job.out_slot = o_slot;
		job.last = (o_row == h - 1'b1) && out_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= rbb_pkg::FW_RESET;
			fh_q <= rbb_pkg::FH_RESET;
			in_row_q <= '0;
			in_col_q <= '0;
			in_slot_q <= '0;
			n_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			out_slot_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == rbb_pkg::CFG_FRAME_WIDTH || cfg_index == rbb_pkg::CFG_FRAME_HEIGHT) begin
				if (cfg_index == rbb_pkg::CFG_FRAME_WIDTH) begin
					fw_q <= cfg_data[rbb_pkg::FW_W-1:0];
				end else begin
					fh_q <= cfg_data[rbb_pkg::FH_W-1:0];
				end
				in_row_q <= '0;
				in_col_q <= '0;
				in_slot_q <= '0;
				n_q <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
				out_slot_q <= '0;
			end
		end else if (accept && (is_pixel || emit)) begin
			if (is_pixel) begin
				n_q <= cur_n + 1'b1;
				if (in_wrap) begin
					in_col_q <= '0;
					in_row_q <= cur_row + 1'b1;
					in_slot_q <= (cur_slot == rbb_pkg::SLOT_W'(RING - 1)) ? '0 : cur_slot + 1'b1;
				end else begin
					in_col_q <= cur_col + 1'b1;
					in_row_q <= cur_row;
					in_slot_q <= cur_slot;
				end
			end
			if (emit) begin
				if (out_wrap) begin
					out_col_q <= '0;
					out_row_q <= o_row + 1'b1;
					out_slot_q <= (o_slot == rbb_pkg::SLOT_W'(RING - 1)) ? '0 : o_slot + 1'b1;
				end else begin
					out_col_q <= o_col + 1'b1;
					out_row_q <= o_row;
					out_slot_q <= o_slot;
				end
			end else begin
				out_col_q <= o_col;
				out_row_q <= o_row;
				out_slot_q <= o_slot;
			end
		end
	end

endmodule

### rtl/rbb_back.sv
// Back end of the box blur: line store writes, window scan with channel sums,
// restoring division by the tap count, and the output register.
// Depends on rbb_pkg and rbb_ram.
module rbb_back #(
	parameter int MAX_WIDTH = rbb_pkg::DEF_MAX_WIDTH,
	parameter int RADIUS = rbb_pkg::DEF_RADIUS
) (
	input  logic clk,
	input  logic arst_n,
	input  rbb_pkg::job_t head,
	input  logic empty,
	output logic pop,
	input  rbb_pkg::geom_t geom,
	output logic out_valid,
	input  logic out_stall,
	output logic [rbb_pkg::CH_W-1:0] blur_red,
	output logic [rbb_pkg::CH_W-1:0] blur_green,
	output logic [rbb_pkg::CH_W-1:0] blur_blue,
	output logic frame_last
);

	localparam int RING = 2 * RADIUS + 2;
	localparam int WIN = 2 * RADIUS + 1;
	localparam int DEPTH = RING * MAX_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int TAP_W = $clog2(WIN);
	localparam int BIT_W = $clog2(rbb_pkg::SUM_W);
	localparam int SL_W = rbb_pkg::SLOT_W + 2;

	rbb_pkg::bk_state_t state_q, state_d;
	rbb_pkg::job_t job_q;
	logic [TAP_W-1:0] dr_q, dc_q;
	logic [rbb_pkg::CNT_W-1:0] cnt_q;
	logic [rbb_pkg::SUM_W-1:0] sum_q [3];
	logic [rbb_pkg::CNT_W-1:0] rem_q [3];
	logic [BIT_W-1:0] bit_q;
	logic rd_v_s1;
	logic out_valid_q;

	logic we, re, load, tap_last, row_in, col_in;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [rbb_pkg::PIX_W-1:0] rdata;
	logic [rbb_pkg::ROW_W:0] rr_ext;
	logic [rbb_pkg::COL_W:0] cc_ext;
	logic [rbb_pkg::COL_W-1:0] cc;
	logic [SL_W-1:0] sl_a, sl_b;
	logic [rbb_pkg::SLOT_W-1:0] rd_slot;

	assign tap_last = (dr_q == TAP_W'(WIN - 1)) && (dc_q == TAP_W'(WIN - 1));
	assign load = !out_valid_q || !out_stall;

	always_comb begin
		rr_ext = (rbb_pkg::ROW_W+1)'(job_q.out_row) + (rbb_pkg::ROW_W+1)'(dr_q);
		cc_ext = (rbb_pkg::COL_W+1)'(job_q.out_col) + (rbb_pkg::COL_W+1)'(dc_q);
		row_in = (rr_ext >= (rbb_pkg::ROW_W+1)'(RADIUS))
			&& (rr_ext - (rbb_pkg::ROW_W+1)'(RADIUS) < (rbb_pkg::ROW_W+1)'(geom.h));
		col_in = (cc_ext >= (rbb_pkg::COL_W+1)'(RADIUS))
			&& (cc_ext - (rbb_pkg::COL_W+1)'(RADIUS) < geom.w);
		cc = rbb_pkg::COL_W'(cc_ext - (rbb_pkg::COL_W+1)'(RADIUS));
		sl_a = SL_W'(job_q.out_slot) + SL_W'(dr_q) + SL_W'(RING - RADIUS);
		sl_b = (sl_a >= SL_W'(RING)) ? sl_a - SL_W'(RING) : sl_a;
		rd_slot = rbb_pkg::SLOT_W'((sl_b >= SL_W'(RING)) ? sl_b - SL_W'(RING) : sl_b);
		raddr = ADDR_W'(rd_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cc);
		waddr = ADDR_W'(head.wr_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(head.wr_col);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rbb_pkg::BK_IDLE: begin
				if (!empty && head.emit) begin
					state_d = rbb_pkg::BK_SCAN;
				end
			end
			rbb_pkg::BK_SCAN: begin
				if (tap_last) begin
					state_d = rbb_pkg::BK_FLUSH;
				end
			end
			rbb_pkg::BK_FLUSH: state_d = rbb_pkg::BK_DIV;
			rbb_pkg::BK_DIV: begin
				if (bit_q == BIT_W'(rbb_pkg::SUM_W - 1)) begin
					state_d = rbb_pkg::BK_OUT;
				end
			end
			rbb_pkg::BK_OUT: begin
				if (load) begin
					state_d = rbb_pkg::BK_IDLE;
				end
			end
			default: state_d = rbb_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		we = 1'b0;
		re = 1'b0;
		unique case (state_q)
			rbb_pkg::BK_IDLE: begin
				pop = !empty;
				we = !empty && head.wr;
			end
			rbb_pkg::BK_SCAN: re = row_in && col_in;
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	rbb_ram #(
		.WIDTH(rbb_pkg::PIX_W),
		.DEPTH(DEPTH)
	) u_line_store (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(head.pix),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbb_pkg::BK_IDLE;
			rd_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= re;
			if (state_q == rbb_pkg::BK_OUT && load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
			dr_q <= '0;
			dc_q <= '0;
			cnt_q <= '0;
			for (int k = 0; k < 3; k++) begin
				sum_q[k] <= '0;
			end
		end else begin
			if (state_q == rbb_pkg::BK_SCAN) begin
				if (dc_q == TAP_W'(WIN - 1)) begin
					dc_q <= '0;
					dr_q <= dr_q + 1'b1;
				end else begin
					dc_q <= dc_q + 1'b1;
				end
				if (re) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (rd_v_s1) begin
				for (int k = 0; k < 3; k++) begin
					sum_q[k] <= sum_q[k] + rbb_pkg::SUM_W'(rdata[k*rbb_pkg::CH_W +: rbb_pkg::CH_W]);
				end
			end
			if (state_q == rbb_pkg::BK_FLUSH) begin
				bit_q <= '0;
				for (int k = 0; k < 3; k++) begin
					rem_q[k] <= '0;
				end
			end
			if (state_q == rbb_pkg::BK_DIV) begin
				bit_q <= bit_q + 1'b1;
				for (int k = 0; k < 3; k++) begin
					if ({rem_q[k], sum_q[k][rbb_pkg::SUM_W-1]} >= {1'b0, cnt_q}) begin
						rem_q[k] <= rbb_pkg::CNT_W'({rem_q[k], sum_q[k][rbb_pkg::SUM_W-1]}
							- {1'b0, cnt_q});
						sum_q[k] <= {sum_q[k][rbb_pkg::SUM_W-2:0], 1'b1};
					end else begin
						rem_q[k] <= rbb_pkg::CNT_W'({rem_q[k], sum_q[k][rbb_pkg::SUM_W-1]});
						sum_q[k] <= {sum_q[k][rbb_pkg::SUM_W-2:0], 1'b0};
					end
				end
			end
		end
		if (state_q == rbb_pkg::BK_OUT && load) begin
			blur_red <= sum_q[0][rbb_pkg::CH_W-1:0];
			blur_green <= sum_q[1][rbb_pkg::CH_W-1:0];
			blur_blue <= sum_q[2][rbb_pkg::CH_W-1:0];
			frame_last <= job_q.last;
		end
	end

	assign out_valid = out_valid_q;

	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbb_pkg::BK_DIV) |-> (cnt_q != '0))
		else $error("window tap count is zero at divide");
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		re |-> !we)
		else $error("line store written during window scan");
	a_read_data_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == rbb_pkg::BK_SCAN || state_q == rbb_pkg::BK_FLUSH))
		else $error("line store read data arrived outside the scan");

endmodule

### rtl/rgb_box_blur_5x5.sv
// Top level of the RGB 5x5 box blur: front end, job queue and back end.
// Depends on rbb_pkg, rbb_front, rbb_fifo and rbb_back.
//
// Usage: pixels of one frame enter in raster order on the input channel
// (in_valid/in_stall) with op clear; each pixel after the first
// RADIUS*width + min(RADIUS, width-1) yields one blurred pixel on the output
// channel (out_valid/out_stall). After the frame, items with op set drain the
// pending outputs, one per item; frame_last marks the frame's final pixel.
// Configuration writes on cfg_valid/cfg_ready set frame width (index 0) and
// height (index 1) and restart the frame; write them only while idle.
// A pixel that causes no output is written to the line store and needs no window
// scan. A pixel or drain item that causes an output takes one line store read per
// in-frame window tap, then a one-bit-per-cycle division of the three channel
// sums. The queue holds two jobs, so the front end keeps taking items while the
// back end works. Reset clears all positions and restores width and height to
// 1024. When the receiver stalls, the result is held and the back end waits.
module rgb_box_blur_5x5 #(
	parameter int MAX_WIDTH = rbb_pkg::DEF_MAX_WIDTH,
	parameter int RADIUS = rbb_pkg::DEF_RADIUS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic op,
	input  logic [rbb_pkg::CH_W-1:0] red,
	input  logic [rbb_pkg::CH_W-1:0] green,
	input  logic [rbb_pkg::CH_W-1:0] blue,
	output logic out_valid,
	input  logic out_stall,
	output logic [rbb_pkg::CH_W-1:0] blur_red,
	output logic [rbb_pkg::CH_W-1:0] blur_green,
	output logic [rbb_pkg::CH_W-1:0] blur_blue,
	output logic frame_last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rbb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic push, pop, full, empty;
	rbb_pkg::job_t job_in, job_head;
	rbb_pkg::geom_t geom;

	rbb_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.RADIUS(RADIUS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.red(red),
		.green(green),
		.blue(blue),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.job(job_in),
		.full(full),
		.geom(geom)
	);

	rbb_fifo #(
		.DEPTH(rbb_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(job_in),
		.full(full),
		.pop(pop),
		.rdata(job_head),
		.empty(empty)
	);

	rbb_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.RADIUS(RADIUS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(job_head),
		.empty(empty),
		.pop(pop),
		.geom(geom),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.blur_red(blur_red),
		.blur_green(blur_green),
		.blur_blue(blur_blue),
		.frame_last(frame_last)
	);

endmodule

### sim/blur_checker.sv
// Checker for the RGB 5x5 box blur: watches the configuration, input and output
// channels, predicts each blurred pixel and compares it field by field.
// Depends on rbb_pkg.
`timescale 1ns / 100ps
module blur_checker
	import rbb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic op,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [CH_W-1:0] blur_red,
	input  logic [CH_W-1:0] blur_green,
	input  logic [CH_W-1:0] blur_blue,
	input  logic frame_last,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int fail_count,
	output int pending
);
	localparam int RING_ROWS = 6;
	localparam int MAX_W = DEF_MAX_WIDTH;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic last;
	} blur_px_t;

	blur_px_t expected_px[$];
	logic [PIX_W-1:0] row_ring [RING_ROWS*MAX_W];
	logic [FW_W-1:0] width_reg;
	logic [FH_W-1:0] height_reg;
	int in_r, in_c, out_r, out_c;

	function automatic int act_width();
		int w;
		w = int'(width_reg);
		if (w == 0) w = 1;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic int act_height();
		int h;
		h = int'(height_reg);
		return (h == 0) ? 1 : h;
	endfunction

	task automatic predict_blur(input int w, input int h);
		blur_px_t px;
		int sr, sg, sb, cnt, rr, cc;
		logic [PIX_W-1:0] p;
		sr = 0; sg = 0; sb = 0; cnt = 0;
		for (int dr = -DEF_RADIUS; dr <= DEF_RADIUS; dr++) begin
			for (int dc = -DEF_RADIUS; dc <= DEF_RADIUS; dc++) begin
				rr = out_r + dr;
				cc = out_c + dc;
				if (rr >= 0 && cc >= 0 && rr < h && cc < w) begin
					p = row_ring[(rr % RING_ROWS) * MAX_W + cc];
					sr += int'(p[7:0]);
					sg += int'(p[15:8]);
					sb += int'(p[23:16]);
					cnt++;
				end
			end
		end
		if (cnt == 0) cnt = 1;
		px.r = CH_W'(sr / cnt);
		px.g = CH_W'(sg / cnt);
		px.b = CH_W'(sb / cnt);
		px.last = (out_r == h - 1 && out_c == w - 1);
		expected_px.push_back(px);
		out_c++;
		if (out_c >= w) begin
			out_c = 0;
			out_r++;
		end
	endtask

	task automatic take_item(input logic drain, input logic [PIX_W-1:0] pix);
		int w, h, lag, n;
		w = act_width();
		h = act_height();
		lag = DEF_RADIUS * w + ((DEF_RADIUS < w - 1) ? DEF_RADIUS : w - 1);
		if (drain == OP_PIXEL) begin
			if (in_r >= h || in_c >= w) begin
				in_r = 0; in_c = 0; out_r = 0; out_c = 0;
			end
			row_ring[(in_r % RING_ROWS) * MAX_W + in_c] = pix;
			n = in_r * w + in_c;
			in_c++;
			if (in_c >= w) begin
				in_c = 0;
				in_r++;
			end
			if (n >= lag && out_r < h) predict_blur(w, h);
		end else if (in_r >= h && out_r < h) begin
			predict_blur(w, h);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		blur_px_t want;
		if (!arst_n) begin
			expected_px.delete();
			width_reg = FW_RESET;
			height_reg = FH_RESET;
			in_r = 0; in_c = 0; out_r = 0; out_c = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_px.size() == 0) begin
					$display("%0t: unexpected item, expected none, got %0d %0d %0d last %0b",
						$time, blur_red, blur_green, blur_blue, frame_last);
					fail_count++;
				end else begin
					want = expected_px.pop_front();
					if (blur_red !== want.r) begin
						$display("%0t: blur_red expected %0d, got %0d", $time, want.r, blur_red);
						fail_count++;
					end
					if (blur_green !== want.g) begin
						$display("%0t: blur_green expected %0d, got %0d", $time, want.g,
							blur_green);
						fail_count++;
					end
					if (blur_blue !== want.b) begin
						$display("%0t: blur_blue expected %0d, got %0d", $time, want.b,
							blur_blue);
						fail_count++;
					end
					if (frame_last !== want.last) begin
						$display("%0t: frame_last expected %0b, got %0b", $time, want.last,
							frame_last);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT) begin
					if (cfg_index == CFG_FRAME_WIDTH) width_reg = cfg_data[FW_W-1:0];
					else height_reg = cfg_data[FH_W-1:0];
					in_r = 0; in_c = 0; out_r = 0; out_c = 0;
				end
			end
			if (in_valid && !in_stall) take_item(op, {blue, green, red});
			pending = expected_px.size();
		end
	end
endmodule

### sim/tb_top.sv
// Top of the RGB 5x5 box blur testbench: clock, reset, stimulus and verdict.
// Depends on rbb_pkg, rgb_box_blur_5x5 and blur_checker.
`timescale 1ns / 100ps
module tb_top;
	import rbb_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_stall, op;
	logic [CH_W-1:0] red, green, blue;
	logic out_valid, out_stall;
	logic [CH_W-1:0] blur_red, blur_green, blur_blue;
	logic frame_last;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count, pending;
	int items, taken;
	bit burst;

	rgb_box_blur_5x5 DUT (.*);

	blur_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	task automatic send_item(input logic o, input logic [7:0] r, g, b);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		op = o;
		red = r;
		green = g;
		blue = b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
		items++;
	endtask

	task automatic put_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic settle();
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic run_frame(input int w, input int h, input int npix, input bit drain);
		int lag;
		lag = 2 * w + ((2 < w - 1) ? 2 : w - 1);
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
			send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
		end
		if (drain) repeat (lag + $urandom_range(0, 2)) send_item(OP_DRAIN, 8'($urandom), 8'd0, 8'd0);
	endtask

	initial begin
		int w, h, wraw, hraw, nfr;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_PIXEL;
		red = '0;
		green = '0;
		blue = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		burst = 1'b0;
		items = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		put_cfg(CFG_FRAME_WIDTH, 13'd3);
		put_cfg(CFG_FRAME_HEIGHT, 13'd2);
		send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
		send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
		send_item(OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
		send_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
		send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		repeat (3) send_item(OP_PIXEL, 8'h80, 8'h7F, 8'h01);
		repeat (7) send_item(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
		settle();
		put_cfg(2'd2, 13'h1FFF);
		put_cfg(2'd3, 13'h1FFF);
		put_cfg(CFG_FRAME_WIDTH, 13'd0);
		put_cfg(CFG_FRAME_HEIGHT, 13'd0);
		send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		repeat (3) send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
		settle();

		put_cfg(CFG_FRAME_WIDTH, 13'h1FFF);
		put_cfg(CFG_FRAME_HEIGHT, 13'd2);
		run_frame(1024, 2, 30, 1'b0);
		settle();
		put_cfg(CFG_FRAME_WIDTH, 13'd1024);
		put_cfg(CFG_FRAME_HEIGHT, 13'h1FFF);
		run_frame(1024, 8191, 20, 1'b0);
		settle();
		put_cfg(CFG_FRAME_WIDTH, 13'd1);
		put_cfg(CFG_FRAME_HEIGHT, 13'h1FFF);
		run_frame(1, 8191, 40, 1'b0);
		settle();

		while (items < 1850) begin
			burst = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0: wraw = 0;
				1: wraw = $urandom_range(1025, 2047);
				default: wraw = $urandom_range(1, 10);
			endcase
			hraw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
			w = (wraw == 0) ? 1 : ((wraw > 1024) ? 1024 : wraw);
			h = (hraw == 0) ? 1 : hraw;
			if ($urandom_range(0, 1)) begin
				put_cfg(CFG_FRAME_HEIGHT, hraw[12:0]);
				put_cfg(CFG_FRAME_WIDTH, {2'($urandom_range(0, 3)), wraw[10:0]});
			end else begin
				put_cfg(CFG_FRAME_WIDTH, {2'($urandom_range(0, 3)), wraw[10:0]});
				put_cfg(CFG_FRAME_HEIGHT, hraw[12:0]);
			end
			if ($urandom_range(0, 7) == 0)
				put_cfg(CFG_IDX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom));
			if (w > 10) begin
				run_frame(w, h, $urandom_range(1, 40), 1'b0);
			end else begin
				nfr = $urandom_range(1, 3);
				for (int f = 0; f < nfr; f++)
					run_frame(w, h, w * h, (f == nfr - 1) || ($urandom_range(0, 3) != 0));
			end
			settle();
		end

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		int hold;
		out_stall = 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = burst ? 0 : $urandom_range(0, 5);
			if (taken == 150) hold = 500;
			out_stall = (hold != 0);
			repeat (hold) @(negedge clk);
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end
endmodule
